// ===== src/afp_pkg.sv =====
// Package: shared types, widths and constants for the affine-from-three-pairs unit.
package afp_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = COORD_BITS + DIFF_BITS;
    localparam int LIN_BITS   = PROD_BITS + 2;
    localparam int INNER_BITS = 2 * COORD_BITS + 1;
    localparam int TRI_BITS   = INNER_BITS + COORD_BITS;
    localparam int TRN_BITS   = TRI_BITS + 2;
    localparam int NUM_BITS   = TRN_BITS + 12;
    localparam int LSH_BITS   = LIN_BITS + 16;
    localparam int MAG_BITS   = NUM_BITS;
    localparam int DEN_BITS   = LIN_BITS;
    localparam int Q_BITS     = 33;
    localparam int REM_BITS   = DEN_BITS + 1;
    localparam int NUM_TERMS  = 6;
    localparam int DIV_STAGES = Q_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [31:0]           q16_t;

    typedef struct packed {
        coord_t src_x0;
        coord_t src_y0;
        coord_t src_x1;
        coord_t src_y1;
        coord_t src_x2;
        coord_t src_y2;
        coord_t dst_x0;
        coord_t dst_y0;
        coord_t dst_x1;
        coord_t dst_y1;
        coord_t dst_x2;
        coord_t dst_y2;
    } afp_req_t;

    typedef struct packed {
        q16_t lin_xx;
        q16_t lin_xy;
        q16_t lin_yx;
        q16_t lin_yy;
        q16_t shift_x;
        q16_t shift_y;
        logic valid_res;
    } afp_res_t;

    // One division lane: numerator magnitude and result sign going into the divider.
    typedef struct packed {
        logic [MAG_BITS-1:0] num_mag;
        logic                neg;
    } div_lane_t;

endpackage

// ===== src/affine_from_three_point_pairs_unit.sv =====
// Top level: affine map from three point pairs, fully pipelined.
//
//  channel  | signals                    | direction | handshake
//  ---------+----------------------------+-----------+----------------------------
//  request  | start, busy, req (struct)  | in        | taken when start && !busy
//  result   | done, res (struct)         | out       | one-cycle strobe, no stall
//
// From the accepting edge to the done strobe a request passes 4 numerator stages,
// 35 divider stages (input register, 33 quotient bits, output register) and
// 1 output register.
// A new request may enter every cycle; busy is held low at all times.
// Reset clears every valid bit; payload registers are not reset.
// The receiver cannot stall, so nothing is ever held back.
module affine_from_three_point_pairs_unit
    import afp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  afp_req_t req,
    output logic     done,
    output afp_res_t res
);

    logic                num_vld;
    logic                det_zero;
    logic [DEN_BITS-1:0] den_mag;
    div_lane_t           lane [NUM_TERMS];
    logic [NUM_TERMS-1:0] div_vld;
    q16_t                quo [NUM_TERMS];

    // Track the degenerate flag alongside the divider pipe, its output
    // register included.
    logic                zero_reg [DIV_STAGES+2];

    // The pipe never stalls, so the request side is always open.
    assign busy = 1'b0;

    afp_numer u_numer (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (start && !busy),
        .in_req       (req),
        .out_vld      (num_vld),
        .out_det_zero (det_zero),
        .out_den_mag  (den_mag),
        .out_lane     (lane)
    );

    // Six lanes share the divisor; a zero divisor flows through harmlessly
    // and the output is forced to zero below.
    for (genvar k = 0; k < NUM_TERMS; k++)
    begin : g_div
        afp_div u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_vld  (num_vld),
            .num_mag (lane[k].num_mag),
            .neg     (lane[k].neg),
            .den_mag (den_mag),
            .out_vld (div_vld[k]),
            .quo     (quo[k])
        );
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= det_zero;
        for (int s = 1; s <= DIV_STAGES + 1; s++)
            zero_reg[s] <= zero_reg[s-1];
    end

    // Output register: drop the quotients of a degenerate triangle.
    logic     done_next;
    afp_res_t res_next;

    always_comb
    begin
        done_next = div_vld[0];
        if (zero_reg[DIV_STAGES+1])
        begin
            res_next = '0;
        end
        else
        begin
            res_next.lin_xx    = quo[0];
            res_next.lin_xy    = quo[1];
            res_next.lin_yx    = quo[2];
            res_next.lin_yy    = quo[3];
            res_next.shift_x   = quo[4];
            res_next.shift_y   = quo[5];
            res_next.valid_res = 1'b1;
        end
    end

    logic done_reg;
    afp_res_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== src/afp_numer.sv =====
// Numerator front end: determinant, linear and translation numerators, magnitudes.
module afp_numer
    import afp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  afp_req_t            in_req,
    output logic                out_vld,
    output logic                out_det_zero,
    output logic [DEN_BITS-1:0] out_den_mag,
    output div_lane_t           out_lane [NUM_TERMS]
);

    // stage 1: differences and the inner products of the translation terms
    logic                          s1_vld_reg;
    logic signed [COORD_BITS-1:0]  x_reg [3];
    logic signed [COORD_BITS-1:0]  y_reg [3];
    logic signed [DIFF_BITS-1:0]   dy_reg [3];
    logic signed [DIFF_BITS-1:0]   du_reg [3];
    logic signed [DIFF_BITS-1:0]   dv_reg [3];
    logic signed [INNER_BITS-1:0]  tu_reg [3];
    logic signed [INNER_BITS-1:0]  tv_reg [3];

    // stage 2: products
    logic                          s2_vld_reg;
    logic signed [PROD_BITS-1:0]   pd_reg [3];
    logic signed [PROD_BITS-1:0]   pxx_reg [3];
    logic signed [PROD_BITS-1:0]   pxy_reg [3];
    logic signed [PROD_BITS-1:0]   pyx_reg [3];
    logic signed [PROD_BITS-1:0]   pyy_reg [3];
    logic signed [TRI_BITS-1:0]    ptx_reg [3];
    logic signed [TRI_BITS-1:0]    pty_reg [3];

    // stage 3: sums
    logic                          s3_vld_reg;
    logic signed [LIN_BITS-1:0]    det_reg;
    logic signed [LIN_BITS-1:0]    nlin_reg [4];
    logic signed [TRN_BITS-1:0]    ntr_reg [2];

    logic signed [COORD_BITS-1:0]  ix [3];
    logic signed [COORD_BITS-1:0]  iy [3];
    logic signed [COORD_BITS-1:0]  iu [3];
    logic signed [COORD_BITS-1:0]  iv [3];

    assign ix = '{in_req.src_x0, in_req.src_x1, in_req.src_x2};
    assign iy = '{in_req.src_y0, in_req.src_y1, in_req.src_y2};
    assign iu = '{in_req.dst_x0, in_req.dst_x1, in_req.dst_x2};
    assign iv = '{in_req.dst_y0, in_req.dst_y1, in_req.dst_y2};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            out_vld    <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            out_vld    <= s3_vld_reg;
        end
    end

    // index k pairs (k+1)%3 with (k+2)%3: dy is (k+2)%3 minus (k+1)%3, du and dv the reverse
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            x_reg[k]  <= ix[k];
            y_reg[k]  <= iy[k];
            dy_reg[k] <= DIFF_BITS'(iy[(k+2)%3]) - DIFF_BITS'(iy[(k+1)%3]);
            du_reg[k] <= DIFF_BITS'(iu[(k+1)%3]) - DIFF_BITS'(iu[(k+2)%3]);
            dv_reg[k] <= DIFF_BITS'(iv[(k+1)%3]) - DIFF_BITS'(iv[(k+2)%3]);
            tu_reg[k] <= INNER_BITS'(iy[(k+2)%3] * iu[(k+1)%3])
                       - INNER_BITS'(iy[(k+1)%3] * iu[(k+2)%3]);
            tv_reg[k] <= INNER_BITS'(iy[(k+2)%3] * iv[(k+1)%3])
                       - INNER_BITS'(iy[(k+1)%3] * iv[(k+2)%3]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pd_reg[k]  <= PROD_BITS'(x_reg[k] * dy_reg[k]);
            pxx_reg[k] <= PROD_BITS'(y_reg[k] * du_reg[k]);
            pxy_reg[k] <= -PROD_BITS'(x_reg[k] * du_reg[k]);
            pyx_reg[k] <= PROD_BITS'(y_reg[k] * dv_reg[k]);
            pyy_reg[k] <= -PROD_BITS'(x_reg[k] * dv_reg[k]);
            ptx_reg[k] <= TRI_BITS'(x_reg[k] * tu_reg[k]);
            pty_reg[k] <= TRI_BITS'(x_reg[k] * tv_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg     <= LIN_BITS'(pd_reg[0]) + LIN_BITS'(pd_reg[1]) + LIN_BITS'(pd_reg[2]);
        nlin_reg[0] <= LIN_BITS'(pxx_reg[0]) + LIN_BITS'(pxx_reg[1]) + LIN_BITS'(pxx_reg[2]);
        nlin_reg[1] <= LIN_BITS'(pxy_reg[0]) + LIN_BITS'(pxy_reg[1]) + LIN_BITS'(pxy_reg[2]);
        nlin_reg[2] <= LIN_BITS'(pyx_reg[0]) + LIN_BITS'(pyx_reg[1]) + LIN_BITS'(pyx_reg[2]);
        nlin_reg[3] <= LIN_BITS'(pyy_reg[0]) + LIN_BITS'(pyy_reg[1]) + LIN_BITS'(pyy_reg[2]);
        ntr_reg[0]  <= TRN_BITS'(ptx_reg[0]) + TRN_BITS'(ptx_reg[1]) + TRN_BITS'(ptx_reg[2]);
        ntr_reg[1]  <= TRN_BITS'(pty_reg[0]) + TRN_BITS'(pty_reg[1]) + TRN_BITS'(pty_reg[2]);
    end

    // stage 4: scale, take magnitudes and result signs
    logic signed [MAG_BITS-1:0] scaled [NUM_TERMS];
    logic                       det_neg;

    always_comb
    begin
        det_neg = det_reg[LIN_BITS-1];
        for (int k = 0; k < 4; k++)
            scaled[k] = MAG_BITS'(nlin_reg[k]) <<< 16;
        for (int k = 0; k < 2; k++)
            scaled[4+k] = MAG_BITS'(ntr_reg[k]) <<< 12;
    end

    always_ff @(posedge clk)
    begin
        out_det_zero <= (det_reg == '0);
        out_den_mag  <= det_neg ? DEN_BITS'(-det_reg) : DEN_BITS'(det_reg);
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            out_lane[k].num_mag <= scaled[k][MAG_BITS-1] ? -scaled[k] : scaled[k];
            out_lane[k].neg     <= scaled[k][MAG_BITS-1] ^ det_neg;
        end
    end

endmodule

// ===== src/afp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, saturating to 32 bits.
module afp_div
    import afp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  logic [MAG_BITS-1:0] num_mag,
    input  logic                neg,
    input  logic [DEN_BITS-1:0] den_mag,
    output logic                out_vld,
    output q16_t                quo
);

    // High part: quotient bits above bit 32 only decide saturation.
    localparam int HI_BITS = MAG_BITS - Q_BITS;

    logic                vld_reg  [DIV_STAGES+1];
    logic [MAG_BITS-1:0] num_reg  [DIV_STAGES+1];
    logic [DEN_BITS-1:0] den_reg  [DIV_STAGES+1];
    logic                neg_reg  [DIV_STAGES+1];
    logic                ovf_reg  [DIV_STAGES+1];
    logic [REM_BITS-1:0] rem_reg  [DIV_STAGES+1];
    logic [Q_BITS-1:0]   q_reg    [DIV_STAGES+1];

    // Stage 0: the high bits give a nonzero quotient bit above bit 32 iff
    // their value alone reaches the divisor; the remainder carries on.
    logic [HI_BITS-1:0]  hi_part;
    logic                hi_ovf;

    assign hi_part = num_mag[MAG_BITS-1:Q_BITS];
    assign hi_ovf  = ({{(MAG_BITS-DEN_BITS){1'b0}}, den_mag} <= MAG_BITS'(hi_part));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s <= DIV_STAGES; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg[0] <= num_mag;
        den_reg[0] <= den_mag;
        neg_reg[0] <= neg;
        ovf_reg[0] <= hi_ovf;
        // hi_part < den when not overflowing, so it fits the remainder width
        rem_reg[0] <= REM_BITS'(hi_part);
        q_reg[0]   <= '0;
    end

    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_stage
        logic [REM_BITS:0]   trial;
        logic [REM_BITS:0]   diff;
        always_comb
        begin
            trial = {rem_reg[s-1], num_reg[s-1][Q_BITS-s]};
            diff  = trial - {2'b00, den_reg[s-1]};
        end
        always_ff @(posedge clk)
        begin
            num_reg[s] <= num_reg[s-1];
            den_reg[s] <= den_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
            ovf_reg[s] <= ovf_reg[s-1];
            if (!diff[REM_BITS])
            begin
                rem_reg[s] <= diff[REM_BITS-1:0];
                q_reg[s]   <= {q_reg[s-1][Q_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s] <= trial[REM_BITS-1:0];
                q_reg[s]   <= {q_reg[s-1][Q_BITS-2:0], 1'b0};
            end
        end
    end

    logic [Q_BITS-1:0] qf;
    logic              sat;

    assign qf  = q_reg[DIV_STAGES];
    assign sat = ovf_reg[DIV_STAGES]
              || (neg_reg[DIV_STAGES] ? (qf > Q_BITS'(33'h080000000))
                                      : (qf > Q_BITS'(33'h07FFFFFFF)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld <= 1'b0;
        else
            out_vld <= vld_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (sat)
            quo <= neg_reg[DIV_STAGES] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            quo <= neg_reg[DIV_STAGES] ? -qf[31:0] : qf[31:0];
    end

endmodule

// ===== src/afp_checker.sv =====
// Checker: port-level properties of the affine unit, bound to the top level.
module afp_checker
    import afp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input afp_res_t res,
    input logic     done
);

    localparam int LAT = 40;

    // the unit never refuses a request
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // each request gives one result after a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("unrequested result");

    // a degenerate result carries all-zero terms
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !res.valid_res) |-> (res.lin_xx == 0 && res.lin_xy == 0
            && res.lin_yx == 0 && res.lin_yy == 0
            && res.shift_x == 0 && res.shift_y == 0))
        else $error("degenerate result not zero");

endmodule

bind affine_from_three_point_pairs_unit afp_checker u_afp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .res   (res),
    .done  (done)
);

// ===== tb/affine_from_three_point_pairs_checker.sv =====
// Checker: predicts affine results from accepted requests and compares them with the block.
`timescale 1ns / 100ps

module affine_from_three_point_pairs_checker
    import afp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  afp_req_t req,
    input  logic     done,
    input  afp_res_t res,
    output int       fail_count,
    output int       pending
);

    afp_res_t expected_fits[$];

    function automatic logic signed [31:0] div_trunc_sat(logic signed [127:0] num,
                                                         logic signed [63:0] den);
        logic signed [127:0] q;
        begin
            q = num / 128'(signed'(den));
            if (q > 128'sd2147483647)
                return 32'h7FFF_FFFF;
            if (q < -128'sd2147483648)
                return 32'h8000_0000;
            return q[31:0];
        end
    endfunction

    function automatic afp_res_t fit_affine(afp_req_t r);
        logic signed [63:0] x0, y0, x1, y1, x2, y2, u0, v0, u1, v1, u2, v2;
        logic signed [63:0] det, nxx, nxy, nyx, nyy;
        logic signed [127:0] tx, ty;
        afp_res_t f;
        begin
            x0 = r.src_x0; y0 = r.src_y0; x1 = r.src_x1;
            y1 = r.src_y1; x2 = r.src_x2; y2 = r.src_y2;
            u0 = r.dst_x0; v0 = r.dst_y0; u1 = r.dst_x1;
            v1 = r.dst_y1; u2 = r.dst_x2; v2 = r.dst_y2;
            f = '0;
            det = x0 * (y2 - y1) + x1 * (y0 - y2) + x2 * (y1 - y0);
            // Degenerate source triangle: everything stays zero.
            if (det == 0)
                return f;
            nxx = y0 * (u1 - u2) + y1 * (u2 - u0) + y2 * (u0 - u1);
            nxy = x0 * (u2 - u1) + x1 * (u0 - u2) + x2 * (u1 - u0);
            nyx = y0 * (v1 - v2) + y1 * (v2 - v0) + y2 * (v0 - v1);
            nyy = x0 * (v2 - v1) + x1 * (v0 - v2) + x2 * (v1 - v0);
            tx = 128'(x0) * 128'(y2 * u1 - y1 * u2) + 128'(x1) * 128'(y0 * u2 - y2 * u0)
               + 128'(x2) * 128'(y1 * u0 - y0 * u1);
            ty = 128'(x0) * 128'(y2 * v1 - y1 * v2) + 128'(x1) * 128'(y0 * v2 - y2 * v0)
               + 128'(x2) * 128'(y1 * v0 - y0 * v1);
            f.lin_xx    = div_trunc_sat(128'(nxx) <<< 16, det);
            f.lin_xy    = div_trunc_sat(128'(nxy) <<< 16, det);
            f.lin_yx    = div_trunc_sat(128'(nyx) <<< 16, det);
            f.lin_yy    = div_trunc_sat(128'(nyy) <<< 16, det);
            f.shift_x   = div_trunc_sat(tx <<< 12, det);
            f.shift_y   = div_trunc_sat(ty <<< 12, det);
            f.valid_res = 1'b1;
            return f;
        end
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        begin
            if (exp_v !== act_v)
            begin
                $display("%0t mismatch %s: expected %0d actual %0d", $time, name,
                         $signed(exp_v), $signed(act_v));
                fail_count++;
            end
        end
    endtask

    assign pending = expected_fits.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        afp_res_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_fits.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual %h", $time, res);
                    fail_count++;
                end
                else
                begin
                    e = expected_fits.pop_front();
                    check_field("lin_xx", e.lin_xx, res.lin_xx);
                    check_field("lin_xy", e.lin_xy, res.lin_xy);
                    check_field("lin_yx", e.lin_yx, res.lin_yx);
                    check_field("lin_yy", e.lin_yy, res.lin_yy);
                    check_field("shift_x", e.shift_x, res.shift_x);
                    check_field("shift_y", e.shift_y, res.shift_y);
                    check_field("valid_res", 32'(e.valid_res), 32'(res.valid_res));
                end
            end
            if (start && !busy)
                expected_fits.push_back(fit_affine(req));
        end
    end

endmodule

// ===== tb/affine_from_three_point_pairs_unit_tb.sv =====
// Testbench top: drives point-pair requests into the affine unit and gives the verdict.
`timescale 1ns / 100ps

module affine_from_three_point_pairs_unit_tb;
    import afp_pkg::*;

    localparam int RANDOM_REQUESTS = 1530;
    localparam int DRAIN_CYCLES    = 60;     // pipeline is 40 deep
    localparam int WATCHDOG_LIMIT  = 2000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    afp_req_t req;
    logic     done;
    afp_res_t res;
    int       fail_count;
    int       pending;
    int       idle_pct;
    int       quiet_cycles;

    affine_from_three_point_pairs_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    affine_from_three_point_pairs_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: count cycles in which neither side moves anything.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Pick a coordinate: extremes, small values near zero, or anything.
    function automatic coord_t pick_coord();
        begin
            case ($urandom_range(0, 9))
                0:       return coord_t'(16'h7FFF);
                1:       return coord_t'(16'h8000);
                2, 3:    return coord_t'($signed($urandom_range(0, 64)) - 32);
                default: return coord_t'($urandom);
            endcase
        end
    endfunction

    function automatic afp_req_t random_request();
        afp_req_t r;
        begin
            r.src_x0 = pick_coord(); r.src_y0 = pick_coord();
            r.src_x1 = pick_coord(); r.src_y1 = pick_coord();
            r.src_x2 = pick_coord(); r.src_y2 = pick_coord();
            r.dst_x0 = pick_coord(); r.dst_y0 = pick_coord();
            r.dst_x1 = pick_coord(); r.dst_y1 = pick_coord();
            r.dst_x2 = pick_coord(); r.dst_y2 = pick_coord();
            // Now and then copy x0 into x1, repeat a point, or make the points collinear.
            case ($urandom_range(0, 11))
                0: r.src_x1 = r.src_x0;
                1: begin r.src_x1 = r.src_x0; r.src_y1 = r.src_y0; end
                2: begin r.src_y0 = r.src_x0; r.src_y1 = r.src_x1; r.src_y2 = r.src_x2; end
                default: ;
            endcase
            return r;
        end
    endfunction

    // Hand one request over; hold start high until it is taken, with random gaps.
    task automatic send_request(afp_req_t r);
        begin
            while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start <= 1'b1;
            req   <= r;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    initial
    begin
        afp_req_t r;
        int       i;
        rst_n    = 1'b0;
        start    = 1'b0;
        req      = '0;
        idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all zero, all extremes, unit triangle maps, degenerate shapes.
        send_request('0);
        send_request({12{coord_t'(16'h7FFF)}});
        send_request({12{coord_t'(16'h8000)}});
        send_request({12{coord_t'(16'hFFFF)}});
        r = '0;
        r.src_x1 = 16; r.src_y2 = 16;
        r.dst_x0 = 16'sh7FFF; r.dst_y0 = 16'sh8000;
        r.dst_x1 = 16'sh8000; r.dst_y1 = 16'sh7FFF;
        r.dst_x2 = 16'sh7FFF; r.dst_y2 = 16'sh8000;
        send_request(r);                              // tiny det, huge numerators
        r.src_x1 = 1; r.src_y2 = -1;
        send_request(r);                              // smallest nonzero determinant
        r = '0;
        r.src_x0 = 16'sh8000; r.src_y0 = 16'sh8000;
        r.src_x1 = 16'sh7FFF; r.src_y1 = 16'sh8000;
        r.src_x2 = 16'sh8000; r.src_y2 = 16'sh7FFF;
        r.dst_x0 = 16'sh7FFF; r.dst_y0 = 16'sh7FFF;
        r.dst_x1 = 16'sh8000; r.dst_y1 = 16'sh7FFF;
        r.dst_x2 = 16'sh7FFF; r.dst_y2 = 16'sh8000;
        send_request(r);                              // largest determinant
        r.dst_x0 = r.src_x0; r.dst_y0 = r.src_y0; r.dst_x1 = r.src_x1;
        r.dst_y1 = r.src_y1; r.dst_x2 = r.src_x2; r.dst_y2 = r.src_y2;
        send_request(r);                              // identity map
        r.src_x1 = r.src_x0; r.src_y1 = r.src_y0;
        send_request(r);                              // repeated point
        r = '0;
        r.src_x0 = 3; r.src_y0 = 3; r.src_x1 = -5; r.src_y1 = -5; r.src_x2 = 7; r.src_y2 = 7;
        r.dst_x0 = 100;
        send_request(r);                              // collinear points
        r = '0;
        r.src_x1 = 48; r.src_y2 = 32; r.dst_x0 = -7; r.dst_y0 = 5;
        r.dst_x1 = 41; r.dst_y1 = -3; r.dst_x2 = -9; r.dst_y2 = 29;
        send_request(r);                              // uneven quotients: truncation
        r.src_y2 = -32;
        send_request(r);                              // positive determinant
        for (i = 0; i < 8; i++)
            send_request(random_request());

        // Random: go through the idling phases in turn.
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            case ((i * 5) / RANDOM_REQUESTS)
                0: idle_pct = 0;
                1: idle_pct = 58;
                2: idle_pct = 0;
                3: idle_pct = 37;
                default: idle_pct = ($urandom_range(0, 1) != 0) ? 58 : 0;
            endcase
            send_request(random_request());
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
